// ===== hdl/hc3_pkg.sv =====
// ---------------------------------------------------------------------------
// hc3_pkg: shared constants for the 3D Hilbert curve codec
// Axis width default and the mode codes used across the level chain.
// ---------------------------------------------------------------------------
`default_nettype none

package hc3_pkg;

  // default bits per coordinate axis
  localparam int AXIS_BITS_DEF = 10;

  // mode codes carried with every word
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

endpackage : hc3_pkg

`default_nettype wire

// ===== hdl/hc3_cell.sv =====
// ---------------------------------------------------------------------------
// hc3_cell: one level of the Skilling transform
// Holds one word and applies the rotation/reflection of a single bit level:
// encode levels run from the top bit down, decode levels from bit 1 up.
// ---------------------------------------------------------------------------
`default_nettype none

module hc3_cell #(
  parameter int AXIS_BITS = hc3_pkg::AXIS_BITS_DEF,
  parameter int STAGE     = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // upstream side
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic                 up_mode,
  input  wire logic [AXIS_BITS-1:0] up_c0,
  input  wire logic [AXIS_BITS-1:0] up_c1,
  input  wire logic [AXIS_BITS-1:0] up_c2,
  // downstream side
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output logic                      dn_mode,
  output logic [AXIS_BITS-1:0]      dn_c0,
  output logic [AXIS_BITS-1:0]      dn_c1,
  output logic [AXIS_BITS-1:0]      dn_c2
);
  import hc3_pkg::*;

  typedef logic [2:0][AXIS_BITS-1:0] trio_t;

  // bit handled by this cell in each direction
  localparam int ENC_BIT = AXIS_BITS - 1 - STAGE;
  localparam int DEC_BIT = STAGE + 1;
  localparam logic [AXIS_BITS-1:0] ENC_Q   = AXIS_BITS'(1) << ENC_BIT;
  localparam logic [AXIS_BITS-1:0] ENC_LOW = ENC_Q - AXIS_BITS'(1);
  localparam logic [AXIS_BITS-1:0] DEC_Q   = AXIS_BITS'(1) << DEC_BIT;
  localparam logic [AXIS_BITS-1:0] DEC_LOW = DEC_Q - AXIS_BITS'(1);

  // invert axis 0 below q, or swap low bits of axis 0 and axis a
  function automatic trio_t level_op(input trio_t c, input logic [1:0] a,
                                     input logic [AXIS_BITS-1:0] q,
                                     input logic [AXIS_BITS-1:0] low);
    trio_t                r;
    logic [AXIS_BITS-1:0] t;
    r = c;
    if ((r[a] & q) != '0) begin
      r[0] = r[0] ^ low;
    end else begin
      t    = (r[0] ^ r[a]) & low;
      r[0] = r[0] ^ t;
      r[a] = r[a] ^ t;
    end
    return r;
  endfunction

  trio_t c_in, c_enc, c_dec, c_new;
  logic  load;

  // level operation for both directions, chosen by mode
  always_comb begin
    c_in  = {up_c2, up_c1, up_c0};
    c_enc = level_op(level_op(level_op(c_in, 2'd0, ENC_Q, ENC_LOW),
                              2'd1, ENC_Q, ENC_LOW), 2'd2, ENC_Q, ENC_LOW);
    c_dec = level_op(level_op(level_op(c_in, 2'd2, DEC_Q, DEC_LOW),
                              2'd1, DEC_Q, DEC_LOW), 2'd0, DEC_Q, DEC_LOW);
    c_new = (up_mode == MODE_DECODE) ? c_dec : c_enc;
  end

  // stage takes a word when empty or when its word moves on
  assign up_ready = !dn_valid || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      dn_mode <= up_mode;
      dn_c0   <= c_new[0];
      dn_c1   <= c_new[1];
      dn_c2   <= c_new[2];
    end
  end

endmodule : hc3_cell

`default_nettype wire

// ===== hdl/hc3_out.sv =====
// ---------------------------------------------------------------------------
// hc3_out: output stage of the codec
// Finishes encode (Gray encode, interleave), clears the fields of the other
// mode and holds the result word for the consumer.
// ---------------------------------------------------------------------------
`default_nettype none

module hc3_out #(
  parameter int AXIS_BITS = hc3_pkg::AXIS_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  wire logic                   up_mode,
  input  wire logic [AXIS_BITS-1:0]   up_c0,
  input  wire logic [AXIS_BITS-1:0]   up_c1,
  input  wire logic [AXIS_BITS-1:0]   up_c2,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [3*AXIS_BITS-1:0]      index_out,
  output logic [AXIS_BITS-1:0]        x_out,
  output logic [AXIS_BITS-1:0]        y_out,
  output logic [AXIS_BITS-1:0]        z_out
);
  import hc3_pkg::*;

  logic [AXIS_BITS-1:0]   g0, g1, g2, t;
  logic [3*AXIS_BITS-1:0] idx;
  logic                   load;

  // Gray encode, fold in the prefix parity of axis 2, then interleave
  always_comb begin
    g0 = up_c0;
    g1 = up_c1 ^ up_c0;
    g2 = up_c2 ^ g1;
    for (int j = 0; j < AXIS_BITS; j++) begin
      t[j] = ^(g2 >> (j + 1));
    end
    g0 = g0 ^ t;
    g1 = g1 ^ t;
    g2 = g2 ^ t;
    for (int i = 0; i < AXIS_BITS; i++) begin
      idx[3*i+2] = g0[i];
      idx[3*i+1] = g1[i];
      idx[3*i]   = g2[i];
    end
  end

  assign up_ready = !out_valid || out_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  // result word, other mode's fields zero
  always_ff @(posedge clk) begin
    if (load) begin
      if (up_mode == MODE_DECODE) begin
        index_out <= '0;
        x_out     <= up_c0;
        y_out     <= up_c1;
        z_out     <= up_c2;
      end else begin
        index_out <= idx;
        x_out     <= '0;
        y_out     <= '0;
        z_out     <= '0;
      end
    end
  end

endmodule : hc3_out

`default_nettype wire

// ===== hdl/hilbert_curve_3d_codec.sv =====
// Structure: AXIS_BITS-1 level cells plus the output register, each a
//   registered stage between input word accepted and result word valid.
// Throughput: one word per cycle while out_ready is high; each level cell is a stage
//   with its own valid, so bubbles close up; ready passes back combinationally through full stages.
// Reset: synchronous, active high; clears every stage valid, payload is kept.
// ---------------------------------------------------------------------------
// hilbert_curve_3d_codec: 3D Hilbert curve encoder / decoder
// Converts three coordinates to a Hilbert index, or back, by Skilling's
// transpose method, one bit level per cell along a chain of cells.
// ---------------------------------------------------------------------------
`default_nettype none

module hilbert_curve_3d_codec #(
  parameter int AXIS_BITS = hc3_pkg::AXIS_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   mode,
  input  wire logic [AXIS_BITS-1:0]   x_in,
  input  wire logic [AXIS_BITS-1:0]   y_in,
  input  wire logic [AXIS_BITS-1:0]   z_in,
  input  wire logic [3*AXIS_BITS-1:0] index_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [3*AXIS_BITS-1:0]      index_out,
  output logic [AXIS_BITS-1:0]        x_out,
  output logic [AXIS_BITS-1:0]        y_out,
  output logic [AXIS_BITS-1:0]        z_out
);
  import hc3_pkg::*;

  localparam int NCELL = AXIS_BITS - 1;

  logic [NCELL:0]                v, r, m;
  logic [NCELL:0][AXIS_BITS-1:0] c0, c1, c2;
  logic [AXIS_BITS-1:0]          d0, d1, d2;
  logic [AXIS_BITS-1:0]          e0, e1, e2;

  // decode entry: de-interleave, then Gray decode
  always_comb begin
    for (int i = 0; i < AXIS_BITS; i++) begin
      d0[i] = index_in[3*i+2];
      d1[i] = index_in[3*i+1];
      d2[i] = index_in[3*i];
    end
    e2 = d2 ^ d1;
    e1 = d1 ^ d0;
    e0 = d0 ^ (d2 >> 1);
    if (mode == MODE_ENCODE) begin
      e0 = x_in;
      e1 = y_in;
      e2 = z_in;
    end
  end

  assign c0[0]    = e0;
  assign c1[0]    = e1;
  assign c2[0]    = e2;
  assign v[0]     = in_valid;
  assign m[0]     = mode;
  assign in_ready = r[0];

  // chain of level cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hc3_cell #(
      .AXIS_BITS (AXIS_BITS),
      .STAGE     (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (v[k]),
      .up_ready (r[k]),
      .up_mode  (m[k]),
      .up_c0    (c0[k]),
      .up_c1    (c1[k]),
      .up_c2    (c2[k]),
      .dn_valid (v[k+1]),
      .dn_ready (r[k+1]),
      .dn_mode  (m[k+1]),
      .dn_c0    (c0[k+1]),
      .dn_c1    (c1[k+1]),
      .dn_c2    (c2[k+1])
    );
  end

  // finishing and output register
  hc3_out #(
    .AXIS_BITS (AXIS_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (v[NCELL]),
    .up_ready  (r[NCELL]),
    .up_mode   (m[NCELL]),
    .up_c0     (c0[NCELL]),
    .up_c1     (c1[NCELL]),
    .up_c2     (c2[NCELL]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .index_out (index_out),
    .x_out     (x_out),
    .y_out     (y_out),
    .z_out     (z_out)
  );

endmodule : hilbert_curve_3d_codec

`default_nettype wire

// ===== hdl/hc3_checker.sv =====
// ---------------------------------------------------------------------------
// hc3_checker: port-level checks for the Hilbert codec
// Watches reset, both handshakes and the mode-exclusive result fields.
// ---------------------------------------------------------------------------
`default_nettype none

module hc3_checker #(
  parameter int AXIS_BITS = hc3_pkg::AXIS_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [3*AXIS_BITS-1:0] index_out,
  input wire logic [AXIS_BITS-1:0]   x_out,
  input wire logic [AXIS_BITS-1:0]   y_out,
  input wire logic [AXIS_BITS-1:0]   z_out
);
  import hc3_pkg::*;

  // no result word straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // an empty output means the whole chain can take a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a waiting input word stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> in_valid)
    else $error("input word withdrawn before acceptance");

  // a result carries either an index or coordinates, never both
  a_mode_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_out != '0) |-> (x_out == '0 && y_out == '0 && z_out == '0))
    else $error("index and coordinates both non-zero");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(index_out) && $stable(x_out)
                                   && $stable(y_out) && $stable(z_out)))
    else $error("stalled result word changed");

endmodule : hc3_checker

bind hilbert_curve_3d_codec hc3_checker #(
  .AXIS_BITS (AXIS_BITS)
) u_hc3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .index_out (index_out),
  .x_out     (x_out),
  .y_out     (y_out),
  .z_out     (z_out)
);

`default_nettype wire
